FILE: design/pmx_pkg.sv
package pmx_pkg;

  localparam int unsigned NodeW       = 6;
  localparam int unsigned CntW        = 7;
  localparam int unsigned NodeCnt     = 64;
  localparam int unsigned MaxNodesDef = 64;

  typedef struct packed {
    logic [NodeW-1:0] parent_a_node;
    logic [NodeW-1:0] parent_b_node;
    logic [NodeW-1:0] cut_low;
    logic [NodeW-1:0] cut_high;
    logic             last_in;
  } in_t;

  typedef struct packed {
    logic [NodeW-1:0] child_a_node;
    logic [NodeW-1:0] child_b_node;
    logic             last_out;
    logic             bad_input;
  } out_t;

  // one crossover job handed from loader to engine
  typedef struct packed {
    logic [CntW-1:0]  n;
    logic [NodeW-1:0] lo;
    logic [NodeW-1:0] hi;
    logic             bad;
  } desc_t;

endpackage

FILE: design/pmx_ram.sv
module pmx_ram #(
  parameter int unsigned Width = 6,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/pmx_front.sv
module pmx_front import pmx_pkg::*; #(
  parameter int unsigned MAX_NODES = MaxNodesDef,
  localparam int unsigned IdxW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_t                in_data_i,
  // parent store and position map writes
  output logic               we_o,
  output logic [IdxW-1:0]    st_waddr_o,
  output logic [NodeW-1:0]   pos_wdata_o,
  output logic [NodeCnt-1:0] posa_vld_o,
  output logic [NodeCnt-1:0] posb_vld_o,
  // job queue and release from engine
  input  logic               q_full_i,
  output logic               q_push_o,
  output desc_t              q_data_o,
  input  logic               release_i
);

  localparam logic StLoad = 1'b0;
  localparam logic StWait = 1'b1;

  logic               state_q, state_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               bad_q, bad_d;
  logic [NodeW-1:0]   maxa_q, maxa_d, maxb_q, maxb_d;
  logic [NodeCnt-1:0] vlda_q, vlda_d, vldb_q, vldb_d;

  logic            accept, first, store_ok;
  logic [CntW-1:0] n, nm1;
  logic [NodeW-1:0] lo_c, hi_c;

  assign in_ready_o  = (state_q == StLoad) && !q_full_i;
  assign accept      = in_valid_i && in_ready_o;
  assign first       = (cnt_q == '0);
  assign store_ok    = cnt_q < CntW'(MAX_NODES);
  assign we_o        = accept && store_ok;
  assign st_waddr_o  = cnt_q[IdxW-1:0];
  assign pos_wdata_o = cnt_q[NodeW-1:0];
  assign posa_vld_o  = vlda_q;
  assign posb_vld_o  = vldb_q;

  assign n    = cnt_q + CntW'(store_ok);
  assign nm1  = n - CntW'(1);
  assign lo_c = (CntW'(in_data_i.cut_low) > nm1) ? nm1[NodeW-1:0] : in_data_i.cut_low;
  assign hi_c = (CntW'(in_data_i.cut_high) > nm1) ? nm1[NodeW-1:0] : in_data_i.cut_high;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    bad_d    = bad_q;
    maxa_d   = maxa_q;
    maxb_d   = maxb_q;
    vlda_d   = vlda_q;
    vldb_d   = vldb_q;
    q_push_o = 1'b0;
    q_data_o = '0;
    if (state_q == StWait && release_i) begin
      state_d = StLoad;
    end
    if (accept) begin
      if (store_ok) begin
        if (first) begin
          vlda_d = '0;
          vldb_d = '0;
          bad_d  = 1'b0;
          maxa_d = in_data_i.parent_a_node;
          maxb_d = in_data_i.parent_b_node;
        end else begin
          if (vlda_q[in_data_i.parent_a_node] || vldb_q[in_data_i.parent_b_node]) begin
            bad_d = 1'b1;
          end
          if (in_data_i.parent_a_node > maxa_q) maxa_d = in_data_i.parent_a_node;
          if (in_data_i.parent_b_node > maxb_q) maxb_d = in_data_i.parent_b_node;
        end
        vlda_d[in_data_i.parent_a_node] = 1'b1;
        vldb_d[in_data_i.parent_b_node] = 1'b1;
        cnt_d = n;
      end else begin
        bad_d = 1'b1;
      end
      if (in_data_i.last_in) begin
        q_push_o   = 1'b1;
        q_data_o.n = n;
        q_data_o.lo = (lo_c > hi_c) ? hi_c : lo_c;
        q_data_o.hi = (lo_c > hi_c) ? lo_c : hi_c;
        q_data_o.bad = bad_d || (CntW'(maxa_d) >= n) || (CntW'(maxb_d) >= n);
        cnt_d   = '0;
        state_d = StWait;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      cnt_q   <= '0;
      bad_q   <= 1'b0;
      maxa_q  <= '0;
      maxb_q  <= '0;
      vlda_q  <= '0;
      vldb_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      bad_q   <= bad_d;
      maxa_q  <= maxa_d;
      maxb_q  <= maxb_d;
      vlda_q  <= vlda_d;
      vldb_q  <= vldb_d;
    end
  end

endmodule

FILE: design/pmx_queue.sv
module pmx_queue import pmx_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output desc_t data_o
);

  desc_t      ent_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = ent_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

FILE: design/pmx_back.sv
module pmx_back import pmx_pkg::*; #(
  parameter int unsigned MAX_NODES = MaxNodesDef,
  localparam int unsigned IdxW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  input  desc_t              job_i,
  output logic               pop_o,
  output logic               release_o,
  output logic [IdxW-1:0]    st_raddr_o,
  output logic [NodeW-1:0]   pos_raddr_o,
  input  logic [NodeW-1:0]   pa_rdata_i,
  input  logic [NodeW-1:0]   pb_rdata_i,
  input  logic [NodeW-1:0]   posa_rdata_i,
  input  logic [NodeW-1:0]   posb_rdata_i,
  input  logic [NodeCnt-1:0] posa_vld_i,
  input  logic [NodeCnt-1:0] posb_vld_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_t               out_data_o
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StOth   = 4'd1;
  localparam logic [3:0] StPos   = 4'd2;
  localparam logic [3:0] StChk   = 4'd3;
  localparam logic [3:0] StTest  = 4'd4;
  localparam logic [3:0] StOwn   = 4'd5;
  localparam logic [3:0] StMap   = 4'd6;
  localparam logic [3:0] StORd   = 4'd7;
  localparam logic [3:0] StOWr   = 4'd8;

  logic [3:0]           state_q, state_d;
  logic                 side_q, side_d;
  logic [NodeW-1:0]     k_q, k_d, idx_q, idx_d, node_q, node_d;
  logic [NodeW-1:0]     lo_q, lo_d, hi_q, hi_d, paddr_q;
  logic [CntW-1:0]      n_q, n_d, steps_q, steps_d;
  logic                 bad_q, bad_d;
  logic [MAX_NODES-1:0] fa_q, fa_d, fb_q, fb_d;
  logic                 ov_q, ov_d;
  out_t                 out_q, out_d;

  logic [NodeW-1:0] posa_v, posb_v, cha_rdata, chb_rdata, ca, cb, p;
  logic             adv, wa, wb, k_seg;

  assign posa_v = posa_vld_i[paddr_q] ? posa_rdata_i : '0;
  assign posb_v = posb_vld_i[paddr_q] ? posb_rdata_i : '0;
  assign k_seg  = (k_q >= lo_q) && (k_q <= hi_q);
  assign ca = k_seg ? pa_rdata_i : (fa_q[k_q[IdxW-1:0]] ? cha_rdata : pb_rdata_i);
  assign cb = k_seg ? pb_rdata_i : (fb_q[k_q[IdxW-1:0]] ? chb_rdata : pa_rdata_i);
  assign p  = side_q ? posb_v : posa_v;

  always_comb begin
    state_d = state_q; side_d = side_q; k_d = k_q; idx_d = idx_q; node_d = node_q;
    lo_d = lo_q; hi_d = hi_q; n_d = n_q; steps_d = steps_q; bad_d = bad_q;
    fa_d = fa_q; fb_d = fb_q; out_d = out_q;
    ov_d = ov_q && !out_ready_i;
    pop_o = 1'b0; release_o = 1'b0; adv = 1'b0; wa = 1'b0; wb = 1'b0;
    st_raddr_o  = k_q[IdxW-1:0];
    pos_raddr_o = node_q;
    unique case (state_q)
      StIdle: begin
        if (job_valid_i) begin
          pop_o = 1'b1;
          n_d = job_i.n; lo_d = job_i.lo; hi_d = job_i.hi; bad_d = job_i.bad;
          k_d = job_i.lo; side_d = 1'b0;
          fa_d = '0; fb_d = '0;
          state_d = StOth;
        end
      end
      StOth: state_d = StPos;
      StPos: begin
        node_d = side_q ? pa_rdata_i : pb_rdata_i;
        pos_raddr_o = node_d;
        state_d = StChk;
      end
      StChk: begin
        if (p < lo_q || p > hi_q) begin
          idx_d = k_q; steps_d = '0; state_d = StTest;
        end else begin
          adv = 1'b1;
        end
      end
      StTest: begin
        st_raddr_o = idx_q[IdxW-1:0];
        if (idx_q < lo_q || idx_q > hi_q) begin
          if (side_q) begin
            wb = 1'b1; fb_d[idx_q[IdxW-1:0]] = 1'b1;
          end else begin
            wa = 1'b1; fa_d[idx_q[IdxW-1:0]] = 1'b1;
          end
          adv = 1'b1;
        end else if (steps_q >= n_q) begin
          bad_d = 1'b1;
          adv = 1'b1;
        end else begin
          state_d = StOwn;
        end
      end
      StOwn: begin
        pos_raddr_o = side_q ? pb_rdata_i : pa_rdata_i;
        state_d = StMap;
      end
      StMap: begin
        idx_d = side_q ? posa_v : posb_v;
        steps_d = steps_q + CntW'(1);
        state_d = StTest;
      end
      StORd: state_d = StOWr;
      StOWr: begin
        if (!ov_q || out_ready_i) begin
          ov_d = 1'b1;
          out_d.child_a_node = ca;
          out_d.child_b_node = cb;
          out_d.last_out = (CntW'(k_q) == n_q - CntW'(1));
          out_d.bad_input = bad_q;
          if (out_d.last_out) begin
            release_o = 1'b1;
            state_d = StIdle;
          end else begin
            k_d = k_q + NodeW'(1);
            state_d = StORd;
          end
        end
      end
      default: state_d = StIdle;
    endcase
    if (adv) begin
      if (!side_q) begin
        side_d = 1'b1; state_d = StOth;
      end else begin
        side_d = 1'b0;
        if (k_q == hi_q) begin
          k_d = '0; state_d = StORd;
        end else begin
          k_d = k_q + NodeW'(1); state_d = StOth;
        end
      end
    end
  end

  pmx_ram #(.Width(NodeW), .Depth(MAX_NODES)) u_cha (
    .clk_i, .we_i(wa), .waddr_i(idx_q[IdxW-1:0]), .wdata_i(node_q),
    .raddr_i(k_q[IdxW-1:0]), .rdata_o(cha_rdata)
  );
  pmx_ram #(.Width(NodeW), .Depth(MAX_NODES)) u_chb (
    .clk_i, .we_i(wb), .waddr_i(idx_q[IdxW-1:0]), .wdata_i(node_q),
    .raddr_i(k_q[IdxW-1:0]), .rdata_o(chb_rdata)
  );

  always_ff @(posedge clk_i) begin
    paddr_q <= pos_raddr_o;
    out_q   <= out_d;
    side_q <= side_d; k_q <= k_d; idx_q <= idx_d; node_q <= node_d;
    lo_q <= lo_d; hi_q <= hi_d; n_q <= n_d; steps_q <= steps_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      bad_q   <= 1'b0;
      fa_q    <= '0;
      fb_q    <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      bad_q   <= bad_d;
      fa_q    <= fa_d;
      fb_q    <= fb_d;
      ov_q    <= ov_d;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

  a_steps_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StTest) |-> (steps_q <= n_q))
    else $error("chain walk ran past its bound");
  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StOWr) |-> (CntW'(k_q) < n_q))
    else $error("output position beyond child length");
  a_fill_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle && job_valid_i) |=> (fa_q == '0 && fb_q == '0))
    else $error("fill flags not cleared at job start");

endmodule

FILE: design/partially_mapped_crossover.sv
// Partially mapped crossover of two permutations.
// Input channel (in_valid_i/in_ready_o/in_data_i): one request per position,
// parent A and parent B nodes side by side; the request with last_in set
// closes the parents and its cut_low/cut_high pick the segment (clamped to
// length-1, swapped when reversed).
// Output channel (out_valid_o/out_ready_i/out_data_o): one request per
// position of the two children, last_out on the final one, bad_input equal
// on every request of a run.
// Loading takes one position per cycle while in_ready_o is high. After the
// last request the engine visits each segment position once per side and
// chases a chain when the mapped node is outside the segment (each chain at
// most N steps, two store lookups per step), then emits the children. Loading of
// the next pair waits until the engine has finished reading the stores.
// A stalled receiver holds the result register; the engine waits on it.
// Reset empties the job queue, drops any partial load and the output.
module partially_mapped_crossover import pmx_pkg::*; #(
  parameter int unsigned MAX_NODES = MaxNodesDef,
  localparam int unsigned IdxW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  logic               we, q_full, q_push, q_valid, pop, rel;
  logic [IdxW-1:0]    st_waddr, st_raddr;
  logic [NodeW-1:0]   pos_wdata, pos_raddr;
  logic [NodeW-1:0]   pa_rdata, pb_rdata, posa_rdata, posb_rdata;
  logic [NodeCnt-1:0] posa_vld, posb_vld;
  desc_t              q_in, q_out;

  // loader: writes parents and position maps, classifies the run
  pmx_front #(.MAX_NODES(MAX_NODES)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .we_o(we), .st_waddr_o(st_waddr), .pos_wdata_o(pos_wdata),
    .posa_vld_o(posa_vld), .posb_vld_o(posb_vld),
    .q_full_i(q_full), .q_push_o(q_push), .q_data_o(q_in), .release_i(rel)
  );

  pmx_queue u_queue (
    .clk_i, .rst_ni, .push_i(q_push), .data_i(q_in), .full_o(q_full),
    .pop_i(pop), .valid_o(q_valid), .data_o(q_out)
  );

  // parent stores indexed by position, maps indexed by node id
  pmx_ram #(.Width(NodeW), .Depth(MAX_NODES)) u_pa (
    .clk_i, .we_i(we), .waddr_i(st_waddr), .wdata_i(in_data_i.parent_a_node),
    .raddr_i(st_raddr), .rdata_o(pa_rdata)
  );
  pmx_ram #(.Width(NodeW), .Depth(MAX_NODES)) u_pb (
    .clk_i, .we_i(we), .waddr_i(st_waddr), .wdata_i(in_data_i.parent_b_node),
    .raddr_i(st_raddr), .rdata_o(pb_rdata)
  );
  pmx_ram #(.Width(NodeW), .Depth(NodeCnt)) u_posa (
    .clk_i, .we_i(we), .waddr_i(in_data_i.parent_a_node), .wdata_i(pos_wdata),
    .raddr_i(pos_raddr), .rdata_o(posa_rdata)
  );
  pmx_ram #(.Width(NodeW), .Depth(NodeCnt)) u_posb (
    .clk_i, .we_i(we), .waddr_i(in_data_i.parent_b_node), .wdata_i(pos_wdata),
    .raddr_i(pos_raddr), .rdata_o(posb_rdata)
  );

  // engine: segment copy, chain chase, gap fill, output
  pmx_back #(.MAX_NODES(MAX_NODES)) u_back (
    .clk_i, .rst_ni, .job_valid_i(q_valid), .job_i(q_out), .pop_o(pop),
    .release_o(rel), .st_raddr_o(st_raddr), .pos_raddr_o(pos_raddr),
    .pa_rdata_i(pa_rdata), .pb_rdata_i(pb_rdata),
    .posa_rdata_i(posa_rdata), .posb_rdata_i(posb_rdata),
    .posa_vld_i(posa_vld), .posb_vld_i(posb_vld),
    .out_valid_o, .out_ready_i, .out_data_o
  );

endmodule

FILE: tb/partially_mapped_crossover_tb.sv
module partially_mapped_crossover_tb;
  import pmx_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxN = MaxNodesDef;
  localparam int unsigned WatchdogLimit = 200000;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_data_o;

  partially_mapped_crossover u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // predictor state: parents loaded so far in the current run
  logic [NodeW-1:0] par_a_q[MaxN];
  logic [NodeW-1:0] par_b_q[MaxN];
  int unsigned      load_cnt;

  out_t child_q[$];   // expected child requests, oldest first
  int   errors;
  bit   idle_en;       // random idling on both sides
  int   quiet_cycles;  // cycles with no accepted request

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    $display("ERROR %0t: %s", $realtime, what);
    errors++;
  endtask

  // Follow own[idx] -> other_pos[..] until idx leaves [lo,hi]; -1 when bound hit.
  function automatic int chain_exit(int unsigned start, int unsigned lo, int unsigned hi,
                                    int unsigned n, logic [NodeW-1:0] own[MaxN],
                                    logic [NodeW-1:0] other_pos[MaxN]);
    int unsigned idx;
    int unsigned steps;
    idx = start;
    steps = 0;
    while (idx >= lo && idx <= hi) begin
      if (steps >= n) return -1;
      idx = other_pos[own[idx]];
      steps++;
    end
    return int'(idx);
  endfunction

  // Position map of one parent; returns 1 if the parent is no permutation.
  function automatic bit map_positions(input logic [NodeW-1:0] par[MaxN], input int unsigned n,
                                       output logic [NodeW-1:0] pos[MaxN]);
    logic [63:0] seen;
    bit bad;
    seen = '0;
    bad = 1'b0;
    for (int k = 0; k < MaxN; k++) pos[k] = '0;
    for (int unsigned k = 0; k < n; k++) begin
      if (par[k] >= n || seen[par[k]]) bad = 1'b1;
      seen[par[k]] = 1'b1;
      pos[par[k]] = NodeW'(k);
    end
    return bad;
  endfunction

  // Absorb one accepted request; on the final one compute both PMX children.
  task automatic predict_crossover(input in_t req);
    logic [NodeW-1:0] pos_a[MaxN];
    logic [NodeW-1:0] pos_b[MaxN];
    logic [NodeW-1:0] kid_a[MaxN];
    logic [NodeW-1:0] kid_b[MaxN];
    logic [1:0]       filled[MaxN];
    bit               bad;
    int unsigned      n, lo, hi, tmp, p;
    int               dst;
    out_t             res;
    bad = 1'b0;
    if (load_cnt < MaxN) begin
      par_a_q[load_cnt] = req.parent_a_node;
      par_b_q[load_cnt] = req.parent_b_node;
      load_cnt++;
    end else begin
      bad = 1'b1;
    end
    if (!req.last_in) return;
    n = load_cnt;
    load_cnt = 0;
    lo = req.cut_low;
    hi = req.cut_high;
    if (lo > n - 1) lo = n - 1;
    if (hi > n - 1) hi = n - 1;
    if (lo > hi) begin
      tmp = lo; lo = hi; hi = tmp;
    end
    if (map_positions(par_a_q, n, pos_a)) bad = 1'b1;
    if (map_positions(par_b_q, n, pos_b)) bad = 1'b1;
    for (int k = 0; k < MaxN; k++) filled[k] = 2'b00;
    for (int unsigned k = lo; k <= hi; k++) begin
      kid_a[k] = par_a_q[k];
      kid_b[k] = par_b_q[k];
      filled[k] = 2'b11;
    end
    for (int unsigned k = lo; k <= hi; k++) begin
      p = pos_a[par_b_q[k]];
      if (p < lo || p > hi) begin
        dst = chain_exit(k, lo, hi, n, par_a_q, pos_b);
        if (dst < 0) bad = 1'b1;
        else begin
          kid_a[dst] = par_b_q[k];
          filled[dst][0] = 1'b1;
        end
      end
      p = pos_b[par_a_q[k]];
      if (p < lo || p > hi) begin
        dst = chain_exit(k, lo, hi, n, par_b_q, pos_a);
        if (dst < 0) bad = 1'b1;
        else begin
          kid_b[dst] = par_a_q[k];
          filled[dst][1] = 1'b1;
        end
      end
    end
    for (int unsigned k = 0; k < n; k++) begin
      res.child_a_node = filled[k][0] ? kid_a[k] : par_b_q[k];
      res.child_b_node = filled[k][1] ? kid_b[k] : par_a_q[k];
      res.last_out     = (k == n - 1);
      res.bad_input    = bad;
      child_q = {child_q, res};
    end
  endtask

  // Sender: optional idle burst, then hold valid until accepted.
  task automatic send_request(input in_t req);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
    predict_crossover(req);
  endtask

  task automatic release_input();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // One parent pair of length n; the final request carries the cuts.
  task automatic send_parents(input logic [NodeW-1:0] pa[$], input logic [NodeW-1:0] pb[$],
                              input logic [NodeW-1:0] lo, input logic [NodeW-1:0] hi);
    in_t req;
    for (int k = 0; k < pa.size(); k++) begin
      req.parent_a_node = pa[k];
      req.parent_b_node = pb[k];
      req.cut_low  = (k == pa.size() - 1) ? lo : NodeW'($urandom);
      req.cut_high = (k == pa.size() - 1) ? hi : NodeW'($urandom);
      req.last_in  = (k == pa.size() - 1);
      send_request(req);
    end
  endtask

  function automatic void shuffled_perm(input int n, output logic [NodeW-1:0] perm[$]);
    logic [NodeW-1:0] t;
    int j;
    perm.delete();
    for (int k = 0; k < n; k++) perm = {perm, NodeW'(k)};
    for (int k = n - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      t = perm[k]; perm[k] = perm[j]; perm[j] = t;
    end
  endfunction

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (child_q.size() != 0) @(posedge clk_i);
  endtask

  // Directed: tiny permutations, reversed and oversized cuts, full-width nodes.
  task automatic test_directed();
    logic [NodeW-1:0] pa[$];
    logic [NodeW-1:0] pb[$];
    pa = '{6'd0, 6'd1, 6'd2, 6'd3}; pb = '{6'd3, 6'd2, 6'd1, 6'd0};
    send_parents(pa, pb, 6'd1, 6'd2);
    pa = '{6'd2, 6'd0, 6'd3, 6'd1}; pb = '{6'd1, 6'd3, 6'd0, 6'd2};
    send_parents(pa, pb, 6'd3, 6'd0);      // reversed cuts
    send_parents(pa, pb, 6'd63, 6'd63);    // cuts clamped to length-1
    // out-of-range and repeated nodes
    pa = '{6'd63, 6'd0, 6'd1, 6'd2}; pb = '{6'd0, 6'd0, 6'd1, 6'd63};
    send_parents(pa, pb, 6'd0, 6'd3);
    pa = '{6'd5}; pb = '{6'd5};            // single position, out-of-range node
    send_parents(pa, pb, 6'd0, 6'd0);
    wait_drained();
  endtask

  // Over-length parents: requests past the store depth are dropped, bad_input set.
  task automatic test_overlength();
    in_t req;
    for (int k = 0; k < MaxN + 2; k++) begin
      req.parent_a_node = NodeW'(k);
      req.parent_b_node = NodeW'(MaxN - 1 - (k % MaxN));
      req.cut_low  = 6'd63;
      req.cut_high = 6'd0;
      req.last_in  = (k == MaxN + 1);
      send_request(req);
    end
    wait_drained();   // sender holds off until all children are back
  endtask

  // Random pairs: mostly valid permutations of small length, some corrupt.
  task automatic test_random(input int n_items);
    logic [NodeW-1:0] pa[$];
    logic [NodeW-1:0] pb[$];
    int sent, n;
    sent = 0;
    while (sent < n_items) begin
      n = ($urandom_range(0, 9) == 0) ? MaxN : $urandom_range(2, 10);
      shuffled_perm(n, pa);
      shuffled_perm(n, pb);
      if ($urandom_range(0, 4) == 0) pa[$urandom_range(0, n - 1)] = NodeW'($urandom);
      if ($urandom_range(0, 4) == 0) pb[$urandom_range(0, n - 1)] = NodeW'($urandom);
      send_parents(pa, pb, NodeW'($urandom), NodeW'($urandom));
      sent += n;
    end
    wait_drained();
  endtask

  // Receiver: random stall bursts while idling is on.
  initial begin
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (idle_en && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Checker and watchdog.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("FAIL");
        $finish;
      end
      if (out_valid_o && out_ready_i) begin
        if (child_q.size() == 0) begin
          report_mismatch("child request with none expected");
        end else begin
          out_t want;
          want = child_q.pop_front();
          if (out_data_o.child_a_node !== want.child_a_node)
            report_mismatch($sformatf("child_a_node %0d want %0d",
                                      out_data_o.child_a_node, want.child_a_node));
          if (out_data_o.child_b_node !== want.child_b_node)
            report_mismatch($sformatf("child_b_node %0d want %0d",
                                      out_data_o.child_b_node, want.child_b_node));
          if (out_data_o.last_out !== want.last_out)
            report_mismatch($sformatf("last_out %0b want %0b",
                                      out_data_o.last_out, want.last_out));
          if (out_data_o.bad_input !== want.bad_input)
            report_mismatch($sformatf("bad_input %0b want %0b",
                                      out_data_o.bad_input, want.bad_input));
        end
      end
    end
  end

  initial begin
    errors = 0;
    load_cnt = 0;
    idle_en = 1'b1;
    rst_ni = 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_overlength();
    test_random(30);
    idle_en = 1'b0;   // final stretch at full rate
    test_random(15);
    release_input();
    repeat (50) @(posedge clk_i);
    if (errors == 0 && child_q.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
